// ===== hdl/mre_pkg.sv =====
// ============================================================================
// mre_pkg
// Shared types and constants of the multiply/accumulate and requantize element.
// ============================================================================
package mre_pkg;

    localparam int DATA_W      = 32;
    localparam int WIDE_W      = 64;
    localparam int REG_INDEX_W = 3;
    localparam int SHIFT_Q_W   = 4;

    // register map
    typedef enum logic [REG_INDEX_W-1:0] {
        REG_ALU_ENABLE    = 3'd0,
        REG_COMBINE_MODE  = 3'd1,
        REG_ACT_ENABLE    = 3'd2,
        REG_SHIFT_QUARTER = 3'd3,
        REG_ZERO_POINT    = 3'd4,
        REG_CLAMP_MIN     = 3'd5,
        REG_CLAMP_MAX     = 3'd6,
        REG_BYTE_OUTPUT   = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        COMBINE_ADD    = 2'd0,
        COMBINE_MUL    = 2'd1,
        COMBINE_DATA   = 2'd2,
        COMBINE_WEIGHT = 2'd3
    } combine_mode_t;

    // settings used by the requantize pipe
    typedef struct packed {
        logic                        act_enable;
        logic [SHIFT_Q_W-1:0]        shift_quarter;
        logic signed [DATA_W-1:0]    zero_point;
        logic signed [DATA_W-1:0]    clamp_min;
        logic signed [DATA_W-1:0]    clamp_max;
        logic                        byte_output;
    } rq_cfg_t;

    localparam logic          ALU_ENABLE_RST   = 1'b1;
    localparam combine_mode_t COMBINE_MODE_RST = COMBINE_MUL;
    localparam rq_cfg_t RQ_CFG_RST = '{
        act_enable:    1'b1,
        shift_quarter: '0,
        zero_point:    '0,
        clamp_min:     -32'sd128,
        clamp_max:     32'sd127,
        byte_output:   1'b1
    };

endpackage

// ===== hdl/mre_requant.sv =====
// ============================================================================
// mre_requant
// Three-stage requantize pipe: scale multiply, rounding shift, zero point
// and clamp into the output register.
// ============================================================================
module mre_requant (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mre_pkg::rq_cfg_t                     cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic        [mre_pkg::DATA_W-1:0]    acc_in,
    input  logic signed [mre_pkg::DATA_W-1:0]    sum_in,
    input  logic signed [mre_pkg::DATA_W-1:0]    scale_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [mre_pkg::DATA_W-1:0]    acc_out,
    output logic        [mre_pkg::DATA_W-1:0]    quant_out
);
    import mre_pkg::*;

    logic                     r1_valid_reg;
    logic [DATA_W-1:0]        r1_acc_reg;
    logic signed [WIDE_W-1:0] r1_prod_reg;
    logic                     r2_valid_reg;
    logic [DATA_W-1:0]        r2_acc_reg;
    logic signed [WIDE_W-1:0] r2_shr_reg;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        acc_out_reg;
    logic [DATA_W-1:0]        quant_out_reg;

    logic                     r1_load;
    logic                     r2_load;
    logic                     r3_load;
    logic signed [WIDE_W-1:0] prod;
    logic [5:0]               sh;
    logic [WIDE_W-1:0]        rnd;
    logic signed [WIDE_W-1:0] rounded;
    logic signed [WIDE_W-1:0] shr;
    logic signed [WIDE_W-1:0] zp_ext;
    logic signed [WIDE_W-1:0] lo_ext;
    logic signed [WIDE_W-1:0] hi_ext;
    logic signed [WIDE_W-1:0] biased;
    logic signed [WIDE_W-1:0] upper_cut;
    logic signed [WIDE_W-1:0] clamped;
    logic [DATA_W-1:0]        quant;

    assign r3_load  = !out_valid_reg || out_ready;
    assign r2_load  = !r2_valid_reg || r3_load;
    assign r1_load  = !r1_valid_reg || r2_load;
    assign in_ready = r1_load;

    // stage 1: signed 32x32 scale product
    assign prod = sum_in * scale_in;

    // stage 2: round half up, arithmetic shift by four times the setting
    assign sh      = {cfg.shift_quarter, 2'b00};
    assign rnd     = (WIDE_W'(1) << sh) >> 1;
    assign rounded = r1_prod_reg + $signed(rnd);
    assign shr     = rounded >>> sh;

    // stage 3: zero point, upper bound first then lower bound, optional byte cut
    assign zp_ext    = {{(WIDE_W-DATA_W){cfg.zero_point[DATA_W-1]}}, cfg.zero_point};
    assign lo_ext    = {{(WIDE_W-DATA_W){cfg.clamp_min[DATA_W-1]}}, cfg.clamp_min};
    assign hi_ext    = {{(WIDE_W-DATA_W){cfg.clamp_max[DATA_W-1]}}, cfg.clamp_max};
    assign biased    = r2_shr_reg + zp_ext;
    assign upper_cut = (biased > hi_ext) ? hi_ext : biased;
    assign clamped   = (upper_cut < lo_ext) ? lo_ext : upper_cut;

    always_comb
    begin
        if (!cfg.act_enable)
        begin
            quant = r2_acc_reg;
        end
        else if (cfg.byte_output)
        begin
            quant = {{(DATA_W-8){clamped[7]}}, clamped[7:0]};
        end
        else
        begin
            quant = clamped[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (r1_load)
            begin
                r1_valid_reg <= in_valid;
            end
            if (r2_load)
            begin
                r2_valid_reg <= r1_valid_reg;
            end
            if (r3_load)
            begin
                out_valid_reg <= r2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1_load)
        begin
            r1_acc_reg  <= acc_in;
            r1_prod_reg <= prod;
        end
        if (r2_load)
        begin
            r2_acc_reg <= r1_acc_reg;
            r2_shr_reg <= shr;
        end
        if (r3_load)
        begin
            acc_out_reg   <= r2_acc_reg;
            quant_out_reg <= quant;
        end
    end

    assign out_valid = out_valid_reg;
    assign acc_out   = acc_out_reg;
    assign quant_out = quant_out_reg;

`ifndef SYNTH
    // a stalled output keeps the whole pipe frozen: nothing enters stage 1
    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && r2_valid_reg && r1_valid_reg) |-> !in_ready)
        else $error("requant pipe took a transfer while full and stalled");

    // an item held in stage 2 under stall is still there next cycle
    a_r2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (r2_valid_reg && !r2_load) |=> (r2_valid_reg && $stable(r2_shr_reg)))
        else $error("requant stage 2 lost its item under stall");

    // stage 2 feeds the output register whenever that one frees up
    a_r2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (r2_valid_reg && r3_load) |=> out_valid_reg)
        else $error("requant stage 2 item did not reach the output register");
`endif

endmodule

// ===== hdl/mac_requantize_element_core.sv =====
// ============================================================================
// mac_requantize_element_core
// Per-element multiply/accumulate followed by a rounding-shift requantizer
// with zero point, clamp and optional byte output.
// ============================================================================
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-----------------------------------
// in      | sink      | in_valid/in_ready  | data, weight, bias, scale, acc_in
// out     | source    | out_valid/out_ready| acc_out, quant_out
// cfg     | sink      | cfg_write          | cfg_index, cfg_data
//
// five register stages: combine, accumulate plus bias, scale multiply,
// rounding shift, zero point/clamp into the output register
// one transfer per cycle in and out unless the output stalls; an input item
// passes all five register stages in order before out_valid rises
// reset clears all valid bits and loads the register defaults
// a stall at the output backs up stage by stage; empty stages keep filling
//
module mac_requantize_element_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic        [mre_pkg::REG_INDEX_W-1:0] cfg_index,
    input  logic        [mre_pkg::DATA_W-1:0]      cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [mre_pkg::DATA_W-1:0]      data_value,
    input  logic signed [mre_pkg::DATA_W-1:0]      weight_value,
    input  logic signed [mre_pkg::DATA_W-1:0]      bias_value,
    input  logic signed [mre_pkg::DATA_W-1:0]      scale_value,
    input  logic signed [mre_pkg::DATA_W-1:0]      acc_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mre_pkg::DATA_W-1:0]      acc_out,
    output logic signed [mre_pkg::DATA_W-1:0]      quant_out
);
    import mre_pkg::*;

    // configuration registers
    logic          alu_enable_reg;
    combine_mode_t combine_mode_reg;
    rq_cfg_t       rq_cfg_reg;

    // stage 1: combined data/weight
    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_comb_reg;
    logic [DATA_W-1:0] s1_acc_reg;
    logic [DATA_W-1:0] s1_bias_reg;
    logic [DATA_W-1:0] s1_scale_reg;

    // stage 2: new accumulator and biased sum
    logic              s2_valid_reg;
    logic [DATA_W-1:0] s2_acc_reg;
    logic [DATA_W-1:0] s2_sum_reg;
    logic [DATA_W-1:0] s2_scale_reg;

    logic              s1_load;
    logic              s2_load;
    logic              rq_ready;
    logic [DATA_W-1:0] comb;
    logic [DATA_W-1:0] new_acc;
    logic [DATA_W-1:0] rq_acc_out;
    logic [DATA_W-1:0] rq_quant_out;

    // configuration writes, decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alu_enable_reg   <= ALU_ENABLE_RST;
            combine_mode_reg <= COMBINE_MODE_RST;
            rq_cfg_reg       <= RQ_CFG_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ALU_ENABLE:    alu_enable_reg           <= cfg_data[0];
                REG_COMBINE_MODE:  combine_mode_reg         <= combine_mode_t'(cfg_data[1:0]);
                REG_ACT_ENABLE:    rq_cfg_reg.act_enable    <= cfg_data[0];
                REG_SHIFT_QUARTER: rq_cfg_reg.shift_quarter <= cfg_data[SHIFT_Q_W-1:0];
                REG_ZERO_POINT:    rq_cfg_reg.zero_point    <= cfg_data;
                REG_CLAMP_MIN:     rq_cfg_reg.clamp_min     <= cfg_data;
                REG_CLAMP_MAX:     rq_cfg_reg.clamp_max     <= cfg_data;
                REG_BYTE_OUTPUT:   rq_cfg_reg.byte_output   <= cfg_data[0];
            endcase
        end
    end

    // ready ripples back from the requant pipe; an empty stage always loads
    assign s2_load  = !s2_valid_reg || rq_ready;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    // stage 1 logic: data/weight combine, low 32 bits of the product
    always_comb
    begin
        case (combine_mode_reg)
            COMBINE_ADD:    comb = data_value + weight_value;
            COMBINE_MUL:    comb = data_value * weight_value;
            COMBINE_DATA:   comb = data_value;
            COMBINE_WEIGHT: comb = weight_value;
            default:        comb = data_value;
        endcase
    end

    // stage 2 logic: accumulate, or pass the accumulator with the ALU off
    assign new_acc = alu_enable_reg ? (s1_comb_reg + s1_acc_reg) : s1_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_comb_reg  <= comb;
            s1_acc_reg   <= acc_in;
            s1_bias_reg  <= bias_value;
            s1_scale_reg <= scale_value;
        end
        if (s2_load)
        begin
            s2_acc_reg   <= new_acc;
            s2_sum_reg   <= new_acc + s1_bias_reg;
            s2_scale_reg <= s1_scale_reg;
        end
    end

    // stages 3 to 5, stage 5 being the output register
    mre_requant u_requant (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (rq_cfg_reg),
        .in_valid  (s2_valid_reg),
        .in_ready  (rq_ready),
        .acc_in    (s2_acc_reg),
        .sum_in    ($signed(s2_sum_reg)),
        .scale_in  ($signed(s2_scale_reg)),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .acc_out   (rq_acc_out),
        .quant_out (rq_quant_out)
    );

    assign acc_out   = $signed(rq_acc_out);
    assign quant_out = $signed(rq_quant_out);

`ifndef SYNTH
    // with the output free nothing upstream may stall
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled although the output side is free");

    // an input transfer always lands in stage 1
    a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("input transfer did not reach stage 1");

    // a stage 1 item blocked by stage 2 keeps its operands
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_load) |=> (s1_valid_reg && $stable(s1_comb_reg)))
        else $error("stage 1 item changed under stall");
`endif

endmodule
